>>> rtl/core/alc_pkg.sv
// ---------------------------------------------------------------------------
// alc_pkg: shared definitions for average-link clustering
// Types, status codes and sizing defaults used by the clustering core.
// ---------------------------------------------------------------------------
package alc_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_MAX_DIMS   = 16;
  localparam int COORD_W        = 16;
  localparam int DIST_W         = 32;
  localparam int ID_OUT_W       = 7;
  localparam int SIZE_OUT_W     = 7;
  localparam int STAT_W         = 2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FEW    = 2'd1,
    STAT_RAGGED = 2'd2,
    STAT_BOUND  = 2'd3
  } status_t;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } iter_op_t;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_BLD_RD,
    ST_BLD_MUL,
    ST_BLD_ACC,
    ST_SQRT,
    ST_SQRT_WAIT,
    ST_SRCH,
    ST_SRCH_DRAIN,
    ST_SZ_RD,
    ST_SZ_CAP,
    ST_UPD_CHK,
    ST_UPD_MUL,
    ST_UPD_ADD,
    ST_UPD_DIV,
    ST_UPD_WAIT,
    ST_EMIT
  } state_t;

endpackage

>>> rtl/core/alc_ram.sv
// ---------------------------------------------------------------------------
// alc_ram: simple dual-read memory
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
module alc_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [W-1:0]  wd,
  input  logic [AW-1:0] ra_a,
  output logic [W-1:0]  rd_a,
  input  logic [AW-1:0] ra_b,
  output logic [W-1:0]  rd_b
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_a_r;
  logic [W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

>>> rtl/core/alc_iter_unit.sv
// ---------------------------------------------------------------------------
// alc_iter_unit: shared shift-compare-subtract unit
// Integer square root (two bits a step) or division (one bit a step).
// ---------------------------------------------------------------------------
module alc_iter_unit #(
  parameter int UW       = 40,
  parameter int DENW     = 7,
  parameter int SQ_STEPS = 18,
  parameter int DV_STEPS = 40
) (
  input  logic               clk,
  input  logic               rst_n,
  input  alc_pkg::iter_req_t req,
  input  logic [UW-1:0]      operand,
  input  logic [DENW-1:0]    divisor,
  output logic               done,
  output logic [UW-1:0]      result
);
  import alc_pkg::*;

  localparam int CNTW = $clog2(UW + 1);

  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  iter_op_t        op_r;
  logic [UW-1:0]   opd_r, opd_nxt;
  logic [UW-1:0]   rem_r, rem_nxt;
  logic [UW-1:0]   res_r, res_nxt;
  logic [DENW-1:0] den_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [UW-1:0]   rem_sh;
  logic [UW-1:0]   trial;
  logic            ge;
  logic            last_step;

  // The remainder takes the next operand bits, then the trial value is
  // subtracted when it fits; the fit decision is the next result bit.
  always_comb begin
    if (op_r == OP_DIV) begin
      rem_sh = {rem_r[UW-2:0], opd_r[UW-1]};
      trial  = UW'(den_r);
      opd_nxt = {opd_r[UW-2:0], 1'b0};
      last_step = (cnt_r == CNTW'(DV_STEPS - 1));
    end else begin
      rem_sh = {rem_r[UW-3:0], opd_r[UW-1:UW-2]};
      trial  = {res_r[UW-3:0], 2'b01};
      opd_nxt = {opd_r[UW-3:0], 2'b00};
      last_step = (cnt_r == CNTW'(SQ_STEPS - 1));
    end
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    res_nxt  = {res_r[UW-2:0], ge};
    cnt_nxt  = cnt_r + CNTW'(1);
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      run_nxt = 1'b1;
    end else if (run_r && last_step) begin
      run_nxt  = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      opd_r <= operand;
      rem_r <= '0;
      res_r <= '0;
      den_r <= divisor;
      cnt_r <= '0;
    end else if (run_r) begin
      opd_r <= opd_nxt;
      rem_r <= rem_nxt;
      res_r <= res_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

>>> rtl/core/average_link_clustering.sv
// ---------------------------------------------------------------------------
// average_link_clustering: average-link (UPGMA) hierarchical clustering
// Loads points one coordinate a beat, then merges clusters and reports
// one merge event per round, or a single error result.
// ---------------------------------------------------------------------------
// Loading takes one beat per cycle while busy is low; an error result follows
// the end-of-set beat in the next cycle. Each point pair is then accumulated
// and square-rooted; each merge round scans every id pair below the next free id,
// then runs one division per other surviving cluster. Synchronous active-low
// reset returns to idle; no memory clearing pass.
module average_link_clustering #(
  parameter int MAX_POINTS = alc_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIMS   = alc_pkg::DEF_MAX_DIMS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [alc_pkg::COORD_W-1:0]   in_coord_value,
  input  logic                                 in_end_of_point,
  input  logic                                 in_end_of_set,
  output logic                                 out_valid,
  output logic [alc_pkg::ID_OUT_W-1:0]         out_first_cluster,
  output logic [alc_pkg::ID_OUT_W-1:0]         out_second_cluster,
  output logic [alc_pkg::DIST_W-1:0]           out_merge_distance,
  output logic [alc_pkg::SIZE_OUT_W-1:0]       out_merged_size,
  output logic [alc_pkg::STAT_W-1:0]           out_status,
  output logic                                 out_last_result
);
  import alc_pkg::*;

  // Cluster ids run up to twice the point count; new clusters take fresh ids.
  localparam int MAX_IDS = 2 * MAX_POINTS;
  localparam int IDW     = $clog2(MAX_IDS);
  localparam int CW      = IDW + 1;
  localparam int PCW     = $clog2(MAX_POINTS + 1);
  localparam int DCW     = $clog2(MAX_DIMS + 1);
  localparam int PAW     = $clog2(MAX_POINTS * MAX_DIMS);
  localparam int DAW     = $clog2(MAX_IDS * MAX_IDS);
  localparam int SZW     = PCW;
  localparam int PRODW   = 2 * COORD_W;
  localparam int SUM_W   = PRODW + $clog2(MAX_DIMS);
  localparam int SQW     = SUM_W + (SUM_W % 2);
  localparam int NUMW    = DIST_W + SZW + 1;
  localparam int UW      = (SQW > NUMW) ? SQW : NUMW;

  // Distances are kept once per unordered pair, at (lower id, higher id).
  function automatic logic [DAW-1:0] daddr(input logic [IDW-1:0] a,
                                           input logic [IDW-1:0] b);
    logic [IDW-1:0] lo;
    logic [IDW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return DAW'(lo) * DAW'(MAX_IDS) + DAW'(hi);
  endfunction

  // True on the final pair (i < j) of a scan over ids below lim.
  function automatic logic last_pair(input logic [IDW-1:0] i,
                                     input logic [IDW-1:0] j,
                                     input logic [CW-1:0]  lim);
    return ((CW'(j) + CW'(1)) == lim) && ((CW'(i) + CW'(2)) >= lim);
  endfunction

  // Sequencer and loading state.
  state_t             st_r, st_nxt;
  logic [PCW-1:0]     lpts_r, lpts_nxt;
  logic [DCW-1:0]     ldims_r, ldims_nxt;
  logic [DCW-1:0]     lfirst_r, lfirst_nxt;
  status_t            lerr_r, lerr_nxt;
  logic [MAX_IDS-1:0] active_r, active_nxt;

  // Working registers of the clustering phase.
  logic [PCW-1:0]          n_r, n_nxt;
  logic [DCW-1:0]          d_r, d_nxt;
  logic [IDW-1:0]          pi_r, pi_nxt;
  logic [IDW-1:0]          pj_r, pj_nxt;
  logic [DCW-1:0]          t_r, t_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [PRODW-1:0]        prod_r, prod_nxt;
  logic [IDW-1:0]          nid_r, nid_nxt;
  logic [PCW-1:0]          acnt_r, acnt_nxt;
  logic                    found_r, found_nxt;
  logic [DIST_W-1:0]       best_r, best_nxt;
  logic [IDW-1:0]          bi_r, bi_nxt;
  logic [IDW-1:0]          bj_r, bj_nxt;
  logic                    cmpv_r, cmpv_nxt;
  logic [IDW-1:0]          cmpi_r, cmpi_nxt;
  logic [IDW-1:0]          cmpj_r, cmpj_nxt;
  logic [SZW-1:0]          si_r, si_nxt;
  logic [SZW-1:0]          sj_r, sj_nxt;
  logic [SZW-1:0]          sk_r, sk_nxt;
  logic [IDW-1:0]          m_r, m_nxt;
  logic [SZW+DIST_W-1:0]   pa_r, pa_nxt;
  logic [SZW+DIST_W-1:0]   pb_r, pb_nxt;
  logic [NUMW-1:0]         num_r, num_nxt;

  // Result registers.
  logic                  ov_r, ov_nxt;
  logic [ID_OUT_W-1:0]   of_r, of_nxt;
  logic [ID_OUT_W-1:0]   os_r, os_nxt;
  logic [DIST_W-1:0]     od_r, od_nxt;
  logic [SIZE_OUT_W-1:0] oz_r, oz_nxt;
  status_t               ost_r, ost_nxt;
  logic                  ol_r, ol_nxt;

  // Memory and unit hookups.
  logic                pm_we;
  logic [PAW-1:0]      pm_wa, pm_ra_a, pm_ra_b;
  logic [COORD_W-1:0]  pm_rd_a, pm_rd_b;
  logic                dm_we;
  logic [DAW-1:0]      dm_wa, dm_ra_a, dm_ra_b;
  logic [DIST_W-1:0]   dm_wd, dm_rd_a, dm_rd_b;
  logic                sm_we;
  logic [SZW-1:0]      sm_wd, sm_rd_a, sm_rd_b;
  iter_req_t           un_req;
  logic [UW-1:0]       un_opnd;
  logic                un_done;
  logic [UW-1:0]       un_res;

  // Combinational temporaries.
  status_t             ld_err;
  logic [PCW-1:0]      ld_pts;
  logic [DCW-1:0]      ld_dims;
  logic [DCW-1:0]      ld_first;
  logic signed [COORD_W:0] diff;
  logic [COORD_W-1:0]  adiff;
  logic [SZW-1:0]      sz_i, sz_j;

  alc_ram #(.W(COORD_W), .DEPTH(MAX_POINTS * MAX_DIMS), .AW(PAW)) u_point_ram (
    .clk  (clk),
    .we   (pm_we),
    .wa   (pm_wa),
    .wd   (in_coord_value),
    .ra_a (pm_ra_a),
    .rd_a (pm_rd_a),
    .ra_b (pm_ra_b),
    .rd_b (pm_rd_b)
  );

  alc_ram #(.W(DIST_W), .DEPTH(MAX_IDS * MAX_IDS), .AW(DAW)) u_dist_ram (
    .clk  (clk),
    .we   (dm_we),
    .wa   (dm_wa),
    .wd   (dm_wd),
    .ra_a (dm_ra_a),
    .rd_a (dm_rd_a),
    .ra_b (dm_ra_b),
    .rd_b (dm_rd_b)
  );

  // Sizes of merged clusters; original points are known to be singletons.
  alc_ram #(.W(SZW), .DEPTH(MAX_IDS), .AW(IDW)) u_size_ram (
    .clk  (clk),
    .we   (sm_we),
    .wa   (nid_r),
    .wd   (sm_wd),
    .ra_a (bi_r),
    .rd_a (sm_rd_a),
    .ra_b (bj_r),
    .rd_b (sm_rd_b)
  );

  alc_iter_unit #(
    .UW       (UW),
    .DENW     (SZW),
    .SQ_STEPS (SQW / 2),
    .DV_STEPS (NUMW)
  ) u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (un_req),
    .operand (un_opnd),
    .divisor (sk_r),
    .done    (un_done),
    .result  (un_res)
  );

  // Absolute coordinate difference for the squared-distance accumulation.
  always_comb begin
    diff  = $signed({pm_rd_a[COORD_W-1], pm_rd_a}) - $signed({pm_rd_b[COORD_W-1], pm_rd_b});
    adiff = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);
  end

  always_comb begin
    st_nxt     = st_r;
    lpts_nxt   = lpts_r;
    ldims_nxt  = ldims_r;
    lfirst_nxt = lfirst_r;
    lerr_nxt   = lerr_r;
    active_nxt = active_r;
    n_nxt      = n_r;
    d_nxt      = d_r;
    pi_nxt     = pi_r;
    pj_nxt     = pj_r;
    t_nxt      = t_r;
    sum_nxt    = sum_r;
    prod_nxt   = prod_r;
    nid_nxt    = nid_r;
    acnt_nxt   = acnt_r;
    found_nxt  = found_r;
    best_nxt   = best_r;
    bi_nxt     = bi_r;
    bj_nxt     = bj_r;
    cmpv_nxt   = cmpv_r;
    cmpi_nxt   = cmpi_r;
    cmpj_nxt   = cmpj_r;
    si_nxt     = si_r;
    sj_nxt     = sj_r;
    sk_nxt     = sk_r;
    m_nxt      = m_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    num_nxt    = num_r;
    ov_nxt     = 1'b0;
    of_nxt     = of_r;
    os_nxt     = os_r;
    od_nxt     = od_r;
    oz_nxt     = oz_r;
    ost_nxt    = ost_r;
    ol_nxt     = ol_r;

    ld_err   = lerr_r;
    ld_pts   = lpts_r;
    ld_dims  = ldims_r;
    ld_first = lfirst_r;
    sz_i     = (CW'(bi_r) < CW'(n_r)) ? SZW'(1) : sm_rd_a;
    sz_j     = (CW'(bj_r) < CW'(n_r)) ? SZW'(1) : sm_rd_b;

    pm_we   = 1'b0;
    pm_wa   = PAW'(lpts_r) * PAW'(MAX_DIMS) + PAW'(ldims_r);
    pm_ra_a = PAW'(pi_r) * PAW'(MAX_DIMS) + PAW'(t_r);
    pm_ra_b = PAW'(pj_r) * PAW'(MAX_DIMS) + PAW'(t_r);
    dm_we   = 1'b0;
    dm_wa   = daddr(pi_r, pj_r);
    dm_wd   = un_res[DIST_W-1:0];
    dm_ra_a = daddr(pi_r, pj_r);
    dm_ra_b = daddr(bj_r, m_r);
    sm_we   = 1'b0;
    sm_wd   = sz_i + sz_j;
    un_req  = '{start: 1'b0, op: OP_SQRT};
    un_opnd = UW'(sum_r) << (UW - SQW);

    unique case (st_r)
      ST_IDLE: begin
        if (start) begin
          // Once an error is pending nothing more is stored until end of set.
          if (ld_err == STAT_OK) begin
            if ((ld_pts >= PCW'(MAX_POINTS)) || (ld_dims >= DCW'(MAX_DIMS))) begin
              ld_err = STAT_BOUND;
            end else begin
              pm_we   = 1'b1;
              ld_dims = ld_dims + DCW'(1);
              if (in_end_of_point || in_end_of_set) begin
                if (ld_pts == '0) begin
                  ld_first = ld_dims;
                end else if (ld_dims != ld_first) begin
                  ld_err = STAT_RAGGED;
                end
                if (ld_err == STAT_OK) begin
                  ld_pts = ld_pts + PCW'(1);
                end
                ld_dims = '0;
              end
            end
          end
          if (in_end_of_set) begin
            if ((ld_err == STAT_OK) && (ld_pts < PCW'(2))) begin
              ld_err = STAT_FEW;
            end
            if (ld_err != STAT_OK) begin
              ov_nxt  = 1'b1;
              of_nxt  = '0;
              os_nxt  = '0;
              od_nxt  = '0;
              oz_nxt  = '0;
              ost_nxt = ld_err;
              ol_nxt  = 1'b1;
            end else begin
              n_nxt  = ld_pts;
              d_nxt  = ld_first;
              st_nxt = ST_INIT;
            end
            lpts_nxt   = '0;
            ldims_nxt  = '0;
            lfirst_nxt = '0;
            lerr_nxt   = STAT_OK;
          end else begin
            lpts_nxt   = ld_pts;
            ldims_nxt  = ld_dims;
            lfirst_nxt = ld_first;
            lerr_nxt   = ld_err;
          end
        end
      end

      ST_INIT: begin
        for (int x = 0; x < MAX_IDS; x++) begin
          active_nxt[x] = (x < int'(n_r));
        end
        nid_nxt  = IDW'(n_r);
        acnt_nxt = n_r;
        pi_nxt   = '0;
        pj_nxt   = IDW'(1);
        t_nxt    = '0;
        sum_nxt  = '0;
        st_nxt   = ST_BLD_RD;
      end

      ST_BLD_RD: begin
        st_nxt = ST_BLD_MUL;
      end

      ST_BLD_MUL: begin
        prod_nxt = PRODW'(adiff) * PRODW'(adiff);
        st_nxt   = ST_BLD_ACC;
      end

      ST_BLD_ACC: begin
        sum_nxt = sum_r + SUM_W'(prod_r);
        if ((t_r + DCW'(1)) == d_r) begin
          st_nxt = ST_SQRT;
        end else begin
          t_nxt  = t_r + DCW'(1);
          st_nxt = ST_BLD_RD;
        end
      end

      ST_SQRT: begin
        un_req = '{start: 1'b1, op: OP_SQRT};
        st_nxt = ST_SQRT_WAIT;
      end

      ST_SQRT_WAIT: begin
        if (un_done) begin
          dm_we   = 1'b1;
          sum_nxt = '0;
          t_nxt   = '0;
          if (last_pair(pi_r, pj_r, CW'(n_r))) begin
            pi_nxt    = '0;
            pj_nxt    = IDW'(1);
            found_nxt = 1'b0;
            cmpv_nxt  = 1'b0;
            st_nxt    = ST_SRCH;
          end else begin
            if ((CW'(pj_r) + CW'(1)) < CW'(n_r)) begin
              pj_nxt = pj_r + IDW'(1);
            end else begin
              pi_nxt = pi_r + IDW'(1);
              pj_nxt = pi_r + IDW'(2);
            end
            st_nxt = ST_BLD_RD;
          end
        end
      end

      ST_SRCH: begin
        // The pair read last cycle is compared while the next one is read;
        // a strict less-than keeps the first pair in scan order on ties.
        if (cmpv_r && (!found_r || (dm_rd_a < best_r))) begin
          found_nxt = 1'b1;
          best_nxt  = dm_rd_a;
          bi_nxt    = cmpi_r;
          bj_nxt    = cmpj_r;
        end
        cmpv_nxt = active_r[pi_r] && active_r[pj_r];
        cmpi_nxt = pi_r;
        cmpj_nxt = pj_r;
        if (last_pair(pi_r, pj_r, CW'(nid_r))) begin
          st_nxt = ST_SRCH_DRAIN;
        end else if ((CW'(pj_r) + CW'(1)) < CW'(nid_r)) begin
          pj_nxt = pj_r + IDW'(1);
        end else begin
          pi_nxt = pi_r + IDW'(1);
          pj_nxt = pi_r + IDW'(2);
        end
      end

      ST_SRCH_DRAIN: begin
        if (cmpv_r && (!found_r || (dm_rd_a < best_r))) begin
          found_nxt = 1'b1;
          best_nxt  = dm_rd_a;
          bi_nxt    = cmpi_r;
          bj_nxt    = cmpj_r;
        end
        cmpv_nxt = 1'b0;
        st_nxt   = ST_SZ_RD;
      end

      ST_SZ_RD: begin
        st_nxt = ST_SZ_CAP;
      end

      ST_SZ_CAP: begin
        si_nxt = sz_i;
        sj_nxt = sz_j;
        sk_nxt = sz_i + sz_j;
        sm_we  = 1'b1;
        m_nxt  = '0;
        st_nxt = ST_UPD_CHK;
      end

      ST_UPD_CHK: begin
        dm_ra_a = daddr(bi_r, m_r);
        if (m_r == nid_r) begin
          st_nxt = ST_EMIT;
        end else if (active_r[m_r] && (m_r != bi_r) && (m_r != bj_r)) begin
          st_nxt = ST_UPD_MUL;
        end else begin
          m_nxt = m_r + IDW'(1);
        end
      end

      ST_UPD_MUL: begin
        pa_nxt = (SZW + DIST_W)'(si_r) * (SZW + DIST_W)'(dm_rd_a);
        pb_nxt = (SZW + DIST_W)'(sj_r) * (SZW + DIST_W)'(dm_rd_b);
        st_nxt = ST_UPD_ADD;
      end

      ST_UPD_ADD: begin
        num_nxt = NUMW'(pa_r) + NUMW'(pb_r);
        st_nxt  = ST_UPD_DIV;
      end

      ST_UPD_DIV: begin
        un_req  = '{start: 1'b1, op: OP_DIV};
        un_opnd = UW'(num_r) << (UW - NUMW);
        st_nxt  = ST_UPD_WAIT;
      end

      ST_UPD_WAIT: begin
        if (un_done) begin
          dm_we  = 1'b1;
          dm_wa  = daddr(m_r, nid_r);
          m_nxt  = m_r + IDW'(1);
          st_nxt = ST_UPD_CHK;
        end
      end

      ST_EMIT: begin
        active_nxt[bi_r]  = 1'b0;
        active_nxt[bj_r]  = 1'b0;
        active_nxt[nid_r] = 1'b1;
        acnt_nxt = acnt_r - PCW'(1);
        nid_nxt  = nid_r + IDW'(1);
        ov_nxt   = 1'b1;
        of_nxt   = ID_OUT_W'(bi_r);
        os_nxt   = ID_OUT_W'(bj_r);
        od_nxt   = best_r;
        oz_nxt   = SIZE_OUT_W'(sk_r);
        ost_nxt  = STAT_OK;
        ol_nxt   = (acnt_r <= PCW'(2));
        if (acnt_r <= PCW'(2)) begin
          st_nxt = ST_IDLE;
        end else begin
          pi_nxt    = '0;
          pj_nxt    = IDW'(1);
          found_nxt = 1'b0;
          cmpv_nxt  = 1'b0;
          st_nxt    = ST_SRCH;
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      lpts_r   <= '0;
      ldims_r  <= '0;
      lfirst_r <= '0;
      lerr_r   <= STAT_OK;
      active_r <= '0;
      nid_r    <= '0;
      acnt_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      lpts_r   <= lpts_nxt;
      ldims_r  <= ldims_nxt;
      lfirst_r <= lfirst_nxt;
      lerr_r   <= lerr_nxt;
      active_r <= active_nxt;
      nid_r    <= nid_nxt;
      acnt_r   <= acnt_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    pi_r    <= pi_nxt;
    pj_r    <= pj_nxt;
    t_r     <= t_nxt;
    sum_r   <= sum_nxt;
    prod_r  <= prod_nxt;
    found_r <= found_nxt;
    best_r  <= best_nxt;
    bi_r    <= bi_nxt;
    bj_r    <= bj_nxt;
    cmpv_r  <= cmpv_nxt;
    cmpi_r  <= cmpi_nxt;
    cmpj_r  <= cmpj_nxt;
    si_r    <= si_nxt;
    sj_r    <= sj_nxt;
    sk_r    <= sk_nxt;
    m_r     <= m_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    num_r   <= num_nxt;
    of_r    <= of_nxt;
    os_r    <= os_nxt;
    od_r    <= od_nxt;
    oz_r    <= oz_nxt;
    ost_r   <= ost_nxt;
    ol_r    <= ol_nxt;
  end

  assign busy               = (st_r != ST_IDLE);
  assign out_valid          = ov_r;
  assign out_first_cluster  = of_r;
  assign out_second_cluster = os_r;
  assign out_merge_distance = od_r;
  assign out_merged_size    = oz_r;
  assign out_status         = ost_r;
  assign out_last_result    = ol_r;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for average_link_clustering
// Streams point sets one coordinate a beat, predicts every merge event and
// error result with an independent UPGMA model, and checks each result strobe.
// ---------------------------------------------------------------------------
module testbench;
  import alc_pkg::*;

  localparam int NPTS  = DEF_MAX_POINTS;
  localparam int NDIM  = DEF_MAX_DIMS;
  localparam int NIDS  = 2 * NPTS;
  localparam int LIMIT = 8000000;
  localparam int TAIL  = 400;

  // One merge event (or error result) as it appears on the result ports.
  typedef struct {
    logic [ID_OUT_W-1:0]   lo_id;
    logic [ID_OUT_W-1:0]   hi_id;
    logic [DIST_W-1:0]     span;
    logic [SIZE_OUT_W-1:0] size;
    status_t               stat;
    logic                  last;
  } merge_t;

  // One row of the directed table: a coordinate beat repeated reps times,
  // and, where typed, the result that the final beat of the row causes.
  typedef struct {
    logic signed [COORD_W-1:0] coord;
    logic                      eop;
    logic                      eos;
    int                        reps;
    bit                        typed;
    merge_t                    want;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_coord_value = '0;
  logic                      in_end_of_point = 1'b0;
  logic                      in_end_of_set = 1'b0;
  logic                      out_valid;
  logic [ID_OUT_W-1:0]       out_first_cluster;
  logic [ID_OUT_W-1:0]       out_second_cluster;
  logic [DIST_W-1:0]         out_merge_distance;
  logic [SIZE_OUT_W-1:0]     out_merged_size;
  logic [STAT_W-1:0]         out_status;
  logic                      out_last_result;

  average_link_clustering dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_coord_value     (in_coord_value),
    .in_end_of_point    (in_end_of_point),
    .in_end_of_set      (in_end_of_set),
    .out_valid          (out_valid),
    .out_first_cluster  (out_first_cluster),
    .out_second_cluster (out_second_cluster),
    .out_merge_distance (out_merge_distance),
    .out_merged_size    (out_merged_size),
    .out_status         (out_status),
    .out_last_result    (out_last_result)
  );

  always #4 clk = ~clk;

  merge_t pending_merges[$];
  row_t   plan[$];
  int     errors = 0;
  int     cycles = 0;
  int     beats_sent = 0;
  int     burst_left = 0;

  // Shadow copy of the clustering state.
  int          coords[NPTS*NDIM];
  logic [31:0] dmat[NIDS*NIDS];
  int          csize[NIDS];
  bit          live[NIDS];
  int          n_loaded = 0;
  int          dims_now = 0;
  int          dims_first = 0;
  status_t     fault = STAT_OK;

  // Floor of the square root, one result bit per pass from the top down.
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = {32'd0, root | (32'd1 << b)};
      if (trial * trial <= v) root = root | (32'd1 << b);
    end
    return root;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    errors++;
  endtask

  // Appends one expected result to the tail of the queue.
  task automatic queue_result(input merge_t m);
    pending_merges.insert(pending_merges.size(), m);
  endtask

  // Builds the distance matrix, then merges the closest live pair each round.
  // Ties keep the first pair in scan order because only a strictly smaller
  // distance replaces the current best.
  task automatic cluster_points(input bit record);
    int          nxt, alive, bi, bj, k;
    bit          found;
    logic [31:0] best, dv;
    longint unsigned acc, num, si, sj, sk;
    longint      df;
    merge_t      m;
    for (int i = 0; i < NIDS; i++) begin
      csize[i] = (i < n_loaded) ? 1 : 0;
      live[i]  = (i < n_loaded);
    end
    for (int i = 0; i < n_loaded; i++) begin
      for (int j = i + 1; j < n_loaded; j++) begin
        acc = 0;
        for (int t = 0; t < dims_first; t++) begin
          df = longint'(coords[i*NDIM+t]) - longint'(coords[j*NDIM+t]);
          if (df < 0) df = -df;
          acc += longint'(df) * longint'(df);
        end
        dmat[i*NIDS+j] = floor_sqrt(acc);
        dmat[j*NIDS+i] = dmat[i*NIDS+j];
      end
    end
    nxt = n_loaded;
    alive = n_loaded;
    while (alive > 1 && nxt < NIDS) begin
      found = 0;
      best = 0;
      bi = 0;
      bj = 0;
      for (int i = 0; i < nxt; i++) begin
        if (!live[i]) continue;
        for (int j = i + 1; j < nxt; j++) begin
          if (!live[j]) continue;
          dv = dmat[i*NIDS+j];
          if (!found || dv < best) begin
            found = 1;
            best = dv;
            bi = i;
            bj = j;
          end
        end
      end
      if (!found) break;
      k = nxt++;
      si = csize[bi];
      sj = csize[bj];
      sk = si + sj;
      csize[k] = int'(sk);
      for (int q = 0; q < k; q++) begin
        if (!live[q] || q == bi || q == bj) continue;
        num = si * dmat[bi*NIDS+q] + sj * dmat[bj*NIDS+q];
        dmat[k*NIDS+q] = 32'(num / sk);
        dmat[q*NIDS+k] = dmat[k*NIDS+q];
      end
      live[bi] = 0;
      live[bj] = 0;
      live[k] = 1;
      alive--;
      m.lo_id = 7'(bi);
      m.hi_id = 7'(bj);
      m.span  = best;
      m.size  = 7'(sk);
      m.stat  = STAT_OK;
      m.last  = (alive <= 1);
      if (record) queue_result(m);
    end
  endtask

  // Advances the shadow state by one accepted beat; record decides whether
  // the results it causes join the queue of expected merges.
  task automatic predict_beat(input logic signed [COORD_W-1:0] v, input logic eop_in,
                              input logic eos_in, input bit record);
    logic   eop;
    merge_t m;
    eop = eop_in | eos_in;
    if (fault == STAT_OK) begin
      if (n_loaded >= NPTS || dims_now >= NDIM) begin
        fault = STAT_BOUND;
      end else begin
        coords[n_loaded*NDIM+dims_now] = int'(v);
        dims_now++;
        if (eop) begin
          if (n_loaded == 0) dims_first = dims_now;
          else if (dims_now != dims_first) fault = STAT_RAGGED;
          if (fault == STAT_OK) n_loaded++;
          dims_now = 0;
        end
      end
    end
    if (!eos_in) return;
    if (fault == STAT_OK && n_loaded < 2) fault = STAT_FEW;
    if (fault != STAT_OK) begin
      m.lo_id = '0;
      m.hi_id = '0;
      m.span  = '0;
      m.size  = '0;
      m.stat  = fault;
      m.last  = 1'b1;
      if (record) queue_result(m);
    end else begin
      cluster_points(record);
    end
    n_loaded = 0;
    dims_now = 0;
    dims_first = 0;
    fault = STAT_OK;
  endtask

  // Drives one beat at the falling edge and holds it until a rising edge
  // with busy low takes it. Busy only moves at rising edges, so the value
  // seen at the falling edge holds through the next rising edge. Bursts of
  // random length are separated by random gaps; some bursts are long.
  task automatic send_beat(input logic signed [COORD_W-1:0] v, input logic eop,
                           input logic eos, input bit record);
    if (burst_left == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    start = 1'b1;
    in_coord_value = v;
    in_end_of_point = eop;
    in_end_of_set = eos;
    while (busy) @(negedge clk);
    @(posedge clk);
    beats_sent++;
    predict_beat(v, eop, eos, record);
  endtask

  // Holds the sender off until every expected result has arrived.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    wait (pending_merges.size() == 0);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom);
      1: return COORD_W'($urandom_range(0, 3));      // many ties
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return COORD_W'(int'($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  // Sends a set of npts points of dim coordinates each. One point may be
  // given a different count (odd_dim) to make the rows ragged.
  task automatic send_set(input int npts, input int dim, input int odd_pt, input int odd_dim);
    int cnt;
    for (int p = 0; p < npts; p++) begin
      cnt = (p == odd_pt) ? odd_dim : dim;
      for (int t = 0; t < cnt; t++) begin
        if (p == npts - 1 && t == cnt - 1)
          send_beat(pick_coord(), 1'($urandom_range(0, 1)), 1'b1, 1);
        else
          send_beat(pick_coord(), t == cnt - 1, 1'b0, 1);
      end
    end
  endtask

  function automatic merge_t error_result(input status_t s);
    merge_t m;
    m = '{lo_id: '0, hi_id: '0, span: '0, size: '0, stat: s, last: 1'b1};
    return m;
  endfunction

  task automatic add_row(input logic signed [COORD_W-1:0] v, input logic eop, input logic eos,
                         input int reps, input bit typed, input merge_t want);
    row_t r;
    r = '{coord: v, eop: eop, eos: eos, reps: reps, typed: typed, want: want};
    plan.insert(plan.size(), r);
  endtask

  // Result checker: every strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    merge_t w;
    if (rst_n && out_valid) begin
      if (pending_merges.size() == 0) begin
        report_mismatch("unexpected result, first_cluster", out_first_cluster, -1);
      end else begin
        w = pending_merges.pop_front();
        if (out_first_cluster !== w.lo_id)
          report_mismatch("first_cluster", out_first_cluster, w.lo_id);
        if (out_second_cluster !== w.hi_id)
          report_mismatch("second_cluster", out_second_cluster, w.hi_id);
        if (out_merge_distance !== w.span)
          report_mismatch("merge_distance", out_merge_distance, w.span);
        if (out_merged_size !== w.size)
          report_mismatch("merged_size", out_merged_size, w.size);
        if (out_status !== w.stat)
          report_mismatch("status", out_status, w.stat);
        if (out_last_result !== w.last)
          report_mismatch("last_result", out_last_result, w.last);
      end
    end
  end

  // Watchdog: the slowest legal run is far below this many cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    merge_t none, hit;
    int     kind, np, dm;
    none = error_result(STAT_OK);
    hit  = '{lo_id: 7'd0, hi_id: 7'd1, span: 32'd65535, size: 7'd2, stat: STAT_OK,
             last: 1'b1};

    // Directed table. A lone point is too few; two points at opposite
    // extremes give the widest one-dimensional distance.
    add_row(16'sh0100, 1'b0, 1'b1, 1, 1, error_result(STAT_FEW));
    add_row(16'sh8000, 1'b1, 1'b0, 1, 0, none);
    add_row(16'sh7fff, 1'b0, 1'b1, 1, 1, hit);
    // Three evenly spaced points tie on the two adjacent pairs.
    add_row(16'sh0000, 1'b1, 1'b0, 1, 0, none);
    add_row(16'sh0100, 1'b1, 1'b0, 1, 0, none);
    add_row(16'sh0200, 1'b1, 1'b1, 1, 0, none);
    // The second point is shorter than the first; the error that comes
    // first holds even though later points look fine.
    add_row(16'sh0001, 1'b0, 1'b0, 1, 0, none);
    add_row(16'sh0002, 1'b1, 1'b0, 1, 0, none);
    add_row(16'sh0003, 1'b1, 1'b0, 1, 0, none);
    add_row(16'sh0004, 1'b0, 1'b0, 1, 0, none);
    add_row(16'sh0005, 1'b1, 1'b1, 1, 1, error_result(STAT_RAGGED));
    // Seventeen coordinates in one point exceed the dimension bound.
    add_row(16'sh7fff, 1'b0, 1'b0, 16, 0, none);
    add_row(-16'sh0001, 1'b0, 1'b1, 1, 1, error_result(STAT_BOUND));
    // Two identical points at the origin, with end of point on the last beat.
    add_row(16'sh0000, 1'b0, 1'b0, 1, 0, none);
    add_row(16'sh0000, 1'b1, 1'b0, 1, 0, none);
    add_row(16'sh0000, 1'b0, 1'b0, 1, 0, none);
    add_row(16'sh0000, 1'b1, 1'b1, 1, 0, none);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++)
        send_beat(plan[r].coord, plan[r].eop, plan[r].eos, !plan[r].typed);
      if (plan[r].typed) queue_result(plan[r].want);
    end
    drain_results();

    // One full-size set gives the longest chain of merges.
    send_set(NPTS, 1, -1, 0);
    drain_results();

    // Random sets: mostly well formed, with a share of broken ones.
    while (beats_sent < 480) begin
      kind = $urandom_range(0, 99);
      dm = ($urandom_range(0, 9) == 0) ? NDIM : $urandom_range(1, 4);
      if (kind < 78) begin
        send_set($urandom_range(2, 6), dm, -1, 0);
      end else if (kind < 83) begin
        send_set(1, dm, -1, 0);
      end else if (kind < 90) begin
        np = $urandom_range(2, 5);
        send_set(np, dm, $urandom_range(1, np - 1), (dm > 1) ? dm - 1 : dm + 1);
      end else if (kind < 94) begin
        send_set($urandom_range(1, 3), NDIM + $urandom_range(1, 3), -1, 0);
      end else if (kind < 96) begin
        send_set(NPTS + 1, 1, -1, 0);
      end else begin
        send_set($urandom_range(12, 24), $urandom_range(1, 2), -1, 0);
      end
      if ($urandom_range(0, 15) == 0) drain_results();
    end

    @(negedge clk);
    start = 1'b0;
    wait (pending_merges.size() == 0);
    repeat (TAIL) @(posedge clk);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/alc_pkg.sv
rtl/core/alc_ram.sv
rtl/core/alc_iter_unit.sv
rtl/core/average_link_clustering.sv
test/testbench.sv
